>>> src/hacr_pkg.sv
// Shared types and constants for the hi-res artifact color renderer.
// Holds the request and result structs, the stage structs and the color codes.
// No dependencies.
package hacr_pkg;

  // Pixels delivered per request and widths that follow from it.
  localparam int PIX_COUNT = 14;
  localparam int APIX_COUNT = 7;
  localparam int COLOR_W = 3;
  localparam int CNT_W = 4;
  localparam int WIN_W = 11;
  localparam int EDGE_COLUMN = 39;

  // Color codes on the result channel.
  localparam logic [COLOR_W-1:0] CODE_BLACK = 3'd0;
  localparam logic [COLOR_W-1:0] CODE_WHITE = 3'd1;
  localparam logic [COLOR_W-1:0] CODE_BLUE = 3'd2;
  localparam logic [COLOR_W-1:0] CODE_ORANGE = 3'd3;
  localparam logic [COLOR_W-1:0] CODE_GREEN = 3'd4;
  localparam logic [COLOR_W-1:0] CODE_VIOLET = 3'd5;

  // Configuration register indexes.
  localparam logic REG_FILL_MODE = 1'b0;

  typedef struct packed {
    logic [7:0] prev_byte;
    logic [7:0] this_byte;
    logic [7:0] next_byte;
    logic [5:0] column;
  } hacr_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } hacr_out_t;

  // Stage 1 output: the 11-bit pixel window around the byte.
  typedef struct packed {
    logic              valid;
    logic [WIN_W-1:0]  win;
    logic              odd;
    logic              hi;
  } hacr_win_t;

  // Stage 2 output: all display pixels of one byte, pixel 0 in the low slot.
  typedef struct packed {
    logic                               valid;
    logic [PIX_COUNT-1:0][COLOR_W-1:0]  color;
  } hacr_row_t;

  // Phase index (2*phase + bit 7) to color code.
  function automatic logic [COLOR_W-1:0] phase_color(input logic [1:0] idx);
    logic [COLOR_W-1:0] c;
    unique case (idx)
      2'd0: c = CODE_VIOLET;
      2'd1: c = CODE_BLUE;
      2'd2: c = CODE_GREEN;
      default: c = CODE_ORANGE;
    endcase
    return c;
  endfunction

endpackage

>>> src/hacr_window.sv
// First stage: request register, edge handling and pixel window assembly.
// Depends on hacr_pkg.
module hacr_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  hacr_pkg::hacr_in_t  in_req,
  input  logic                take_i,
  output logic                busy,
  output hacr_pkg::hacr_win_t win_o
);
  import hacr_pkg::*;

  logic             valid_r, valid_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic             odd_r, hi_r;
  logic             accept;
  logic [1:0]       prev_bits;
  logic [1:0]       next_bits;

  // The stage is held only while its content cannot move on.
  assign busy   = valid_r && !take_i;
  assign accept = start && !busy;

  // Neighbors read as zero at the screen edges.
  always_comb begin
    prev_bits = (in_req.column == 6'd0) ? 2'b00 : in_req.prev_byte[6:5];
    next_bits = (in_req.column >= 6'(EDGE_COLUMN)) ? 2'b00 : in_req.next_byte[1:0];
    win_nxt   = {next_bits, in_req.this_byte[6:0], prev_bits};
  end

  // Valid bit follows accepts and hand-offs.
  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Window payload is loaded on each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
      odd_r <= in_req.column[0];
      hi_r  <= in_req.this_byte[7];
    end
  end

  assign win_o = '{valid: valid_r, win: win_r, odd: odd_r, hi: hi_r};

endmodule

>>> src/hacr_colorize.sv
// Second stage: per-pixel color rules, fixup pixel and half-pixel shift.
// Depends on hacr_pkg.
module hacr_colorize (
  input  logic                clk,
  input  logic                rst_n,
  input  hacr_pkg::hacr_win_t win_i,
  input  logic                fill_mode,
  input  logic                load_i,
  output logic                take_o,
  output hacr_pkg::hacr_row_t row_o
);
  import hacr_pkg::*;

  logic                               valid_r, valid_nxt;
  logic [PIX_COUNT-1:0][COLOR_W-1:0]  color_r, color_nxt;
  logic [APIX_COUNT-1:0][COLOR_W-1:0] px;
  logic [COLOR_W-1:0]                 fix;

  // Color of the pixel at window bit i (2 to 8).
  function automatic logic [COLOR_W-1:0] apix(
    input logic [WIN_W-1:0] w,
    input int               i,
    input logic             odd,
    input logic             hi,
    input logic             mode
  );
    logic               par;
    logic [COLOR_W-1:0] c;
    par = (i % 2) != 0;
    c   = CODE_BLACK;
    if (w[i]) begin
      if (w[i-1] || w[i+1]) begin
        c = CODE_WHITE;
      end else begin
        c = phase_color({odd ^ par, hi});
      end
    end else if (w[i-1] && w[i+1]) begin
      if (mode || !(w[i-2] && w[i+2])) begin
        c = phase_color({odd ^ par ^ 1'b1, hi});
      end
    end
    return c;
  endfunction

  // Handshake: take from stage 1 when this stage is empty or being drained.
  assign take_o = win_i.valid && (!valid_r || load_i);

  // Seven independent pixel colors.
  always_comb begin
    for (int k = 0; k < APIX_COUNT; k++) begin
      px[k] = apix(win_i.win, k + 2, win_i.odd, win_i.hi, fill_mode);
    end
  end

  // Fixup pixel that leads a shifted byte.
  always_comb begin
    priority if (win_i.win[1] && (win_i.win[2] || win_i.win[0])) begin
      fix = CODE_WHITE;
    end else if (win_i.win[1]) begin
      fix = win_i.odd ? CODE_BLUE : CODE_ORANGE;
    end else if (win_i.win[0] && win_i.win[2] && (fill_mode || !win_i.win[3])) begin
      fix = win_i.odd ? CODE_ORANGE : CODE_BLUE;
    end else begin
      fix = CODE_BLACK;
    end
  end

  // Double each pixel, shifting by one display pixel when bit 7 is set.
  always_comb begin
    for (int k = 0; k < PIX_COUNT; k++) begin
      if (win_i.hi) begin
        color_nxt[k] = (k == 0) ? fix : px[(k - 1) / 2];
      end else begin
        color_nxt[k] = px[k / 2];
      end
    end
  end

  always_comb begin
    if (take_o) begin
      valid_nxt = 1'b1;
    end else if (load_i) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      color_r <= color_nxt;
    end
  end

  assign row_o = '{valid: valid_r, color: color_r};

endmodule

>>> src/hacr_serializer.sv
// Third stage: shifts the display pixels of one byte out, one per cycle.
// Depends on hacr_pkg.
module hacr_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  hacr_pkg::hacr_row_t row_i,
  output logic                load_o,
  output logic                out_strobe,
  output hacr_pkg::hacr_out_t out_res
);
  import hacr_pkg::*;

  logic                               valid_r, valid_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [PIX_COUNT-1:0][COLOR_W-1:0]  shift_r, shift_nxt;
  logic                               last;

  assign last   = cnt_r == CNT_W'(PIX_COUNT - 1);
  // A new row loads behind the last pixel of the current one.
  assign load_o = row_i.valid && (!valid_r || last);

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    if (load_o) begin
      valid_nxt = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = row_i.color;
    end else if (valid_r) begin
      valid_nxt = !last;
      cnt_nxt   = cnt_r + CNT_W'(1);
      shift_nxt = shift_r >> COLOR_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign out_strobe = valid_r;
  assign out_res    = '{pixel_color: shift_r[0], last_pixel: last};

endmodule

>>> src/hires_artifact_color_renderer_unit.sv
// Top level of the hi-res artifact color renderer: configuration port and stage chain.
// Depends on hacr_pkg, hacr_window, hacr_colorize and hacr_serializer.
//
//   Channel  Ports                               Handshake
//   input    start, busy, in_req                 taken when start && !busy
//   result   out_strobe, out_res                 one pixel per strobe, no back-pressure
//   config   psel/penable/pwrite/paddr/pwdata    write on access phase, pready tied high
//
// Each request yields 14 pixels back to back once its window, colorize and
// serializer registers are loaded. The serializer sends one pixel per cycle, so
// it takes a new row only behind the last pixel of the current one, with up to
// two requests queued in the window and colorize stages behind it. Reset (rst_n
// low, synchronous) empties every stage and sets standard fill mode. busy rises
// only when both upstream stages hold a request waiting for the serializer.
module hires_artifact_color_renderer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hacr_pkg::hacr_in_t  in_req,
  output logic                out_strobe,
  output hacr_pkg::hacr_out_t out_res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hacr_pkg::*;

  logic      fill_mode_r, fill_mode_nxt;
  logic      cfg_wr;
  logic      win_take;
  logic      row_load;
  hacr_win_t win;
  hacr_row_t row;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FILL_MODE);
  assign fill_mode_nxt = cfg_wr ? pwdata[0] : fill_mode_r;
  assign prdata = (paddr[2] == REG_FILL_MODE) ? {31'd0, fill_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_mode_r <= 1'b1;
    end else begin
      fill_mode_r <= fill_mode_nxt;
    end
  end

  // Stage chain.
  hacr_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_req),
    .take_i (win_take),
    .busy   (busy),
    .win_o  (win)
  );

  hacr_colorize u_colorize (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_i     (win),
    .fill_mode (fill_mode_r),
    .load_i    (row_load),
    .take_o    (win_take),
    .row_o     (row)
  );

  hacr_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_i      (row),
    .load_o     (row_load),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  // A pixel that is not the last of its byte is always followed by another.
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last_pixel |=> out_strobe)
    else $error("pixel burst broke off before its last pixel");

  // A waiting row starts right behind the last pixel of the current one.
  a_row_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.last_pixel && row.valid |=> out_strobe && !out_res.last_pixel)
    else $error("queued row did not follow the last pixel");

  // Only defined color codes leave the block.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_res.pixel_color <= CODE_VIOLET)
    else $error("undefined color code on the result port");

  // An accepted request always lands in the window stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> win.valid)
    else $error("accepted request was lost");

endmodule

>>> sim/tb_hires_artifact_color_renderer_unit.sv
// Testbench for hires_artifact_color_renderer_unit: byte requests in, 14 pixel colors out.
// Predicts every pixel from the byte, its neighbors, its column and the fill mode.
// Depends on hacr_pkg and the renderer RTL.
module tb_hires_artifact_color_renderer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hacr_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [2:0] FILL_MODE_ADDR = {REG_FILL_MODE, 2'b00};

  typedef logic [PIX_COUNT-1:0][COLOR_W-1:0] pixel_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  hacr_in_t    in_req;
  logic        out_strobe;
  hacr_out_t   out_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the fill mode register and the pixels still to come, oldest first.
  logic        fill_standard;
  hacr_out_t   expected_pixels[$];
  int          mismatch_count;
  int          idle_cycles;

  hires_artifact_color_renderer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Phase index is 2*phase + bit 7.
  function automatic logic [COLOR_W-1:0] phase_to_color(input logic [1:0] idx);
    case (idx)
      2'd0: return CODE_VIOLET;
      2'd1: return CODE_BLUE;
      2'd2: return CODE_GREEN;
      default: return CODE_ORANGE;
    endcase
  endfunction

  // Color of window bit i (2..8): white next to a lit dot, phase color when isolated,
  // and a fill color for a dark dot between two lit ones (in text mode only if the dots two away are not both lit).
  function automatic logic [COLOR_W-1:0] dot_color(input logic [WIN_W-1:0] win, input int i,
                                                   input logic odd, input logic hi,
                                                   input logic std_fill);
    logic par;
    par = (i % 2) == 1;
    if (win[i]) begin
      if (win[i-1] || win[i+1]) return CODE_WHITE;
      return phase_to_color({odd ^ par, hi});
    end
    if (win[i-1] && win[i+1] && (std_fill || !(win[i-2] && win[i+2])))
      return phase_to_color({odd ^ par ^ 1'b1, hi});
    return CODE_BLACK;
  endfunction

  // First display pixel of a shifted byte, from the left neighbor's last dot and the bits around it.
  function automatic logic [COLOR_W-1:0] fixup_color(input logic [WIN_W-1:0] win,
                                                     input logic odd, input logic std_fill);
    if (win[1]) begin
      if (win[2] || win[0]) return CODE_WHITE;
      return odd ? CODE_BLUE : CODE_ORANGE;
    end
    if (win[0] && win[2] && (std_fill || !win[3]))
      return odd ? CODE_ORANGE : CODE_BLUE;
    return CODE_BLACK;
  endfunction

  // All 14 display pixels of one byte, pixel 0 leftmost.
  function automatic pixel_row_t render_byte(input hacr_in_t req, input logic std_fill);
    logic [7:0]         left;
    logic [7:0]         right;
    logic [WIN_W-1:0]   win;
    logic               odd;
    logic               hi;
    logic [COLOR_W-1:0] dots [APIX_COUNT];
    pixel_row_t         row;
    left = (req.column == 6'd0) ? 8'h00 : req.prev_byte;
    right = (req.column >= EDGE_COLUMN) ? 8'h00 : req.next_byte;
    win = {right[1:0], req.this_byte[6:0], left[6:5]};
    odd = req.column[0];
    hi = req.this_byte[7];
    for (int k = 0; k < APIX_COUNT; k++) begin
      dots[k] = dot_color(win, k + 2, odd, hi, std_fill);
    end
    for (int k = 0; k < PIX_COUNT; k++) begin
      if (hi) begin
        row[k] = (k == 0) ? fixup_color(win, odd, std_fill) : dots[(k - 1) / 2];
      end else begin
        row[k] = dots[k / 2];
      end
    end
    return row;
  endfunction

  function automatic hacr_in_t pack_request(input logic [7:0] prev_b, input logic [7:0] cur_b,
                                            input logic [7:0] next_b, input int col);
    hacr_in_t req;
    req.prev_byte = prev_b;
    req.this_byte = cur_b;
    req.next_byte = next_b;
    req.column = 6'(col);
    return req;
  endfunction

  // Half plain random bytes, with sparse and striped bytes to reach the
  // isolated-dot, fill and fringe cases, and columns weighted to the edges.
  function automatic hacr_in_t random_request();
    hacr_in_t   req;
    int         kind;
    int         pick;
    logic [7:0] stripe;
    req.prev_byte = 8'($urandom());
    req.this_byte = 8'($urandom());
    req.next_byte = 8'($urandom());
    kind = $urandom_range(0, 9);
    if (kind >= 4 && kind <= 6) begin
      req.this_byte = {1'($urandom_range(0, 1)), 7'($urandom() & $urandom())};
    end else if (kind >= 7 && kind <= 8) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: stripe = 8'h55;
        1: stripe = 8'h2A;
        2: stripe = 8'h1B;
        3: stripe = 8'h36;
        4: stripe = 8'h6C;
        default: stripe = 8'h5B;
      endcase
      req.this_byte = stripe ^ 8'($urandom() & $urandom() & $urandom());
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) req.column = 6'd0;
    else if (pick == 1) req.column = 6'(EDGE_COLUMN);
    else if (pick == 2) req.column = 6'($urandom_range(40, 63));
    else req.column = 6'($urandom_range(0, 39));
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Present one request and hold it until accepted, then queue its pixels.
  task automatic send_request(input hacr_in_t req);
    pixel_row_t row;
    hacr_out_t  px;
    in_req <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    row = render_byte(req, fill_standard);
    for (int k = 0; k < PIX_COUNT; k++) begin
      px.pixel_color = row[k];
      px.last_pixel = (k == PIX_COUNT - 1);
      expected_pixels.push_back(px);
    end
  endtask

  // Random pause after a request: often none, mostly short, now and then long.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r >= 55) begin
      n = (r < 90) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the end of the access cycle.
  task automatic write_fill_mode(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FILL_MODE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fill_standard = value[0];
  endtask

  // Standard fill mode straight out of reset: edges, stripes, every fixup case.
  task automatic test_directed_standard();
    send_request(pack_request(8'hFF, 8'h00, 8'h00, 0));  // left neighbor ignored at column 0
    idle_gap();
    send_request(pack_request(8'hFF, 8'hFF, 8'hFF, 20));
    idle_gap();
    send_request(pack_request(8'h00, 8'h7F, 8'hFF, 39));  // right neighbor ignored at the edge
    idle_gap();
    send_request(pack_request(8'h00, 8'h55, 8'h00, 10));
    send_request(pack_request(8'h00, 8'h55, 8'h00, 11));
    send_request(pack_request(8'h00, 8'hD5, 8'h00, 10));
    send_request(pack_request(8'h00, 8'hAA, 8'h00, 11));
    idle_gap();
    send_request(pack_request(8'h00, 8'h2A, 8'h00, 12));
    // Shifted bytes: white, lone left dot, and fill across the byte boundary.
    send_request(pack_request(8'h40, 8'h81, 8'h00, 5));
    send_request(pack_request(8'h60, 8'h80, 8'h00, 6));
    send_request(pack_request(8'h40, 8'h80, 8'h00, 8));
    idle_gap();
    send_request(pack_request(8'h40, 8'h80, 8'h00, 9));
    send_request(pack_request(8'h20, 8'h81, 8'h00, 8));
    send_request(pack_request(8'h20, 8'h83, 8'h00, 9));
    send_request(pack_request(8'h00, 8'h05, 8'h00, 14));
    send_request(pack_request(8'h00, 8'h85, 8'h00, 15));
    idle_gap();
    send_request(pack_request(8'h60, 8'h01, 8'h03, 1));
    send_request(pack_request(8'h00, 8'h40, 8'h03, 38));
    // Columns past the edge keep the left neighbor and drop the right one.
    send_request(pack_request(8'h60, 8'hC1, 8'h03, 40));
    send_request(pack_request(8'h60, 8'hC1, 8'h03, 63));
    wait_idle();
  endtask

  // Text-optimized mode: fill between dots is dropped where dots two away are lit.
  task automatic test_directed_text();
    write_fill_mode(32'hFFFF_FFFE);
    send_request(pack_request(8'h00, 8'h1B, 8'h00, 2));
    send_request(pack_request(8'h00, 8'h9B, 8'h00, 3));
    idle_gap();
    send_request(pack_request(8'h20, 8'h83, 8'h00, 4));
    send_request(pack_request(8'h20, 8'h81, 8'h00, 4));
    send_request(pack_request(8'h00, 8'h05, 8'h00, 7));
    send_request(pack_request(8'h60, 8'h6D, 8'h03, 21));
    send_request(pack_request(8'h00, 8'hFF, 8'h00, 20));
    wait_idle();
  endtask

  // Random bytes under one fill mode, with one stretch free of pauses.
  task automatic test_random_rows(input logic mode, input int count);
    logic [31:0] junk;
    int          burst_start;
    int          burst_len;
    junk = $urandom();
    write_fill_mode({junk[31:1], mode});
    burst_start = $urandom_range(0, count / 2);
    burst_len = $urandom_range(10, 30);
    for (int n = 0; n < count; n++) begin
      send_request(random_request());
      if (n < burst_start || n >= burst_start + burst_len) idle_gap();
    end
    wait_idle();
  endtask

  // Check each pixel against the oldest expectation.
  always @(posedge clk) begin
    hacr_out_t want;
    if (rst_n && out_strobe) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel with nothing pending: color %0d last %0b",
                                  out_res.pixel_color, out_res.last_pixel));
      end else begin
        want = expected_pixels.pop_front();
        if (out_res.pixel_color !== want.pixel_color)
          report_mismatch($sformatf("pixel_color got %0d want %0d",
                                    out_res.pixel_color, want.pixel_color));
        if (out_res.last_pixel !== want.last_pixel)
          report_mismatch($sformatf("last_pixel got %0b want %0b",
                                    out_res.last_pixel, want.last_pixel));
      end
    end
  end

  // Watchdog: too long without a request or a pixel moving means a hang.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_hires_artifact_color_renderer_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_cycles <= 0;
    mismatch_count = 0;
    fill_standard = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_standard();
    test_directed_text();
    test_random_rows(1'b0, 80);
    test_random_rows(1'b1, 80);
    test_random_rows(1'b0, 80);
    test_random_rows(1'b1, 80);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_hires_artifact_color_renderer_unit OK");
    end else begin
      $display("tb_hires_artifact_color_renderer_unit NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
src/hacr_pkg.sv
src/hacr_window.sv
src/hacr_colorize.sv
src/hacr_serializer.sv
src/hires_artifact_color_renderer_unit.sv
sim/tb_hires_artifact_color_renderer_unit.sv
